// File: rtl/dbps_pkg.sv
// Types, constants and saturating fixed-point helpers for the division branch point selector.
`default_nettype none

package dbps_pkg;

    localparam int WORD_BITS = 64;
    localparam int IDX_W     = 16;
    localparam int QUO_STEPS = 64;

    localparam logic [63:0] SMAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SMIN = 64'h8000_0000_0000_0000;

    // Configuration register indexes
    localparam logic [1:0] REG_ZERO_TOL = 2'd0;
    localparam logic [1:0] REG_INF_LIM  = 2'd1;
    localparam logic [1:0] REG_MARGIN   = 2'd2;

    // Branch directions
    localparam logic [1:0] WAY_RANDOM = 2'd0;
    localparam logic [1:0] WAY_LEFT   = 2'd1;
    localparam logic [1:0] WAY_RIGHT  = 2'd2;
    localparam logic [1:0] WAY_CENTER = 2'd3;

    // Divider working state for one quotient bit step
    typedef struct packed {
        logic [63:0] d;
        logic [63:0] r;
        logic [63:0] lo;
        logic [63:0] q;
        logic        dz;
        logic        ovf;
        logic        neg;
        logic        a_pos;
        logic        a_neg;
    } div_t;

    // Decision fields that ride alongside the divider
    typedef struct packed {
        logic [15:0] idx;
        logic [1:0]  way;
        logic [1:0]  cnt;
        logic [63:0] p1;
        logic        minmax;
        logic        ysmall;
        logic        use_q;
        logic [63:0] sc_a;
        logic [63:0] sc_b;
    } ctrl_t;

    function automatic logic [63:0] mag(input logic [63:0] v);
        mag = v[63] ? (64'd0 - v) : v;
    endfunction

    function automatic logic [63:0] sat65(input logic [64:0] s);
        if (s[64] != s[63])
            sat65 = s[64] ? SMIN : SMAX;
        else
            sat65 = s[63:0];
    endfunction

    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        sat_add = sat65({a[63], a} + {b[63], b});
    endfunction

    function automatic logic [63:0] sat_sub(input logic [63:0] a, input logic [63:0] b);
        sat_sub = sat65({a[63], a} - {b[63], b});
    endfunction

    function automatic logic [63:0] times10(input logic [63:0] a);
        logic [67:0] t;
        t = {{4{a[63]}}, a} * 68'd10;
        if (t[67:63] == 5'b00000 || t[67:63] == 5'b11111)
            times10 = t[63:0];
        else
            times10 = t[67] ? SMIN : SMAX;
    endfunction

    function automatic logic [63:0] from_mag(input logic neg, input logic [63:0] m,
                                             input logic ovf);
        if (neg)
            from_mag = (ovf || m[63]) ? SMIN : (64'd0 - m);
        else
            from_mag = (ovf || m[63]) ? SMAX : m;
    endfunction

    function automatic logic [63:0] near_point(input logic [63:0] v, input logic [63:0] lo,
                                               input logic [63:0] hi, input logic [32:0] margin,
                                               input logic [63:0] one);
        logic [64:0] dl;
        logic [64:0] dh;
        dl = {v[63], v} - {lo[63], lo};
        dh = {v[63], v} - {hi[63], hi};
        if (dl[64]) dl = 65'd0 - dl;
        if (dh[64]) dh = 65'd0 - dh;
        if (dl < {32'd0, margin})
            near_point = sat_add(sat_add(v, one), times10(lo));
        else if (dh < {32'd0, margin})
            near_point = sat_add(sat_sub(v, one), times10(hi));
        else
            near_point = v;
    endfunction

    function automatic logic [63:0] midpoint(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {a[63], a} + {b[63], b};
        midpoint = s[64:1];
    endfunction

endpackage

`default_nettype wire

// File: rtl/dbps_divider.sv
// Pipelined restoring divider: one quotient bit per stage, decision fields carried along.
`default_nettype none

module dbps_divider (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           adv,
    input  wire logic           in_valid,
    input  wire dbps_pkg::div_t  in_div,
    input  wire dbps_pkg::ctrl_t in_ctrl,
    output logic                out_valid,
    output logic [63:0]         out_quo,
    output dbps_pkg::ctrl_t      out_ctrl
);
    import dbps_pkg::*;

    logic  valid_reg [QUO_STEPS+1];
    div_t  div_reg   [QUO_STEPS+1];
    ctrl_t ctrl_reg  [QUO_STEPS+1];

    assign valid_reg[0] = in_valid;
    assign div_reg[0]   = in_div;
    assign ctrl_reg[0]  = in_ctrl;

    for (genvar i = 0; i < QUO_STEPS; i++) begin : g_step
        logic [64:0] rr;
        logic        ge;
        div_t        div_next;

        // Shift in one numerator bit, subtract when the divisor fits
        always_comb
        begin
            rr          = {div_reg[i].r, div_reg[i].lo[63]};
            ge          = rr >= {1'b0, div_reg[i].d};
            div_next    = div_reg[i];
            div_next.r  = ge ? 64'(rr - {1'b0, div_reg[i].d}) : rr[63:0];
            div_next.lo = {div_reg[i].lo[62:0], 1'b0};
            div_next.q  = {div_reg[i].q[62:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[i+1] <= 1'b0;
            else if (adv)
                valid_reg[i+1] <= valid_reg[i];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                div_reg[i+1]  <= div_next;
                ctrl_reg[i+1] <= ctrl_reg[i];
            end
        end
    end

    // Resolve division by zero and quotient overflow
    always_comb
    begin
        if (div_reg[QUO_STEPS].dz)
            out_quo = div_reg[QUO_STEPS].a_pos ? SMAX :
                      (div_reg[QUO_STEPS].a_neg ? SMIN : 64'd0);
        else if (div_reg[QUO_STEPS].ovf)
            out_quo = div_reg[QUO_STEPS].neg ? SMIN : SMAX;
        else
            out_quo = from_mag(div_reg[QUO_STEPS].neg, div_reg[QUO_STEPS].q, 1'b0);
    end

    assign out_valid = valid_reg[QUO_STEPS];
    assign out_ctrl  = ctrl_reg[QUO_STEPS];

endmodule

`default_nettype wire

// File: rtl/division_branch_point_select.sv
// Branching point selector for a division constraint w = x / y, top level.
//
// Input beats on s_axis_* carry indices, bounds and current values of x, y
// and w; each beat yields exactly one result beat on m_axis_* with the
// branching variable, direction, one or two points and an infeasibility
// score. Values are signed fixed point with FRACTION_BITS fraction bits.
// Three tolerances are set through cfg_wen / cfg_index / cfg_data; the user
// must set them only while the block is idle, which the block itself does
// not enforce; reset loads their defaults. The pipeline is made of an
// input register, a classification and partial-product stage, a
// 64-stage restoring divider that retires one quotient bit per stage, and
// the output register. One beat is accepted every cycle unless stalled.
// The whole pipeline advances only when the output register is empty or
// being taken; when the receiver stalls every stage holds and s_axis_tready
// drops, so no beat is lost or repeated. Reset clears all valid bits and
// leaves the output channel empty.
`default_nettype none

module division_branch_point_select #(
    parameter int FRACTION_BITS = 32,
    parameter int INDEX_BITS    = 16
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // x_index, y_index, w_index, x_low, x_high, x_value, y_low, y_high,
    // y_value, w_low, w_high, w_value
    input  wire logic [623:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // branch_index, branch_way, point_count, first_point, second_point,
    // infeasibility, zero fill
    output logic [215:0]      m_axis_tdata,
    input  wire logic         cfg_wen,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [62:0]  cfg_data
);
    import dbps_pkg::*;

    localparam logic [15:0] IDX_MASK = (INDEX_BITS >= IDX_W) ? 16'hFFFF :
                                       16'((32'd1 << INDEX_BITS) - 32'd1);
    localparam logic [63:0] ONE = 64'd1 << FRACTION_BITS;

    logic        adv;
    logic [32:0] zero_tol_reg;
    logic [62:0] inf_lim_reg;
    logic [32:0] margin_reg;

    assign adv           = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_tol_reg <= 33'd429;
            inf_lim_reg  <= 63'h3B9A_CA00_0000_0000;
            margin_reg   <= 33'd42949673;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                REG_ZERO_TOL: zero_tol_reg <= cfg_data[32:0];
                REG_INF_LIM:  inf_lim_reg  <= cfg_data;
                REG_MARGIN:   margin_reg   <= cfg_data[32:0];
                default: ;
            endcase
        end
    end

    // Input register
    logic         a_valid_reg;
    logic [623:0] a_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (adv)
            a_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            a_data_reg <= s_axis_tdata;
    end

    // Classify the query and pick divider and multiplier operands
    logic [15:0] xi, yi, wi;
    logic [63:0] xl, xu, x0, yl, yu, y0, wl, wu, w0;
    logic [63:0] pinf, ninf, dx, dy, dw, den, ma_y, ma_w;
    logic        ystr, yunb, wlo_u, whi_u, ysmall;
    logic        sel_x, sel_y;
    ctrl_t       ctrl_next;

    always_comb
    begin
        xi = a_data_reg[15:0] & IDX_MASK;
        yi = a_data_reg[31:16] & IDX_MASK;
        wi = a_data_reg[47:32] & IDX_MASK;
        xl = a_data_reg[111:48];
        xu = a_data_reg[175:112];
        x0 = a_data_reg[239:176];
        yl = a_data_reg[303:240];
        yu = a_data_reg[367:304];
        y0 = a_data_reg[431:368];
        wl = a_data_reg[495:432];
        wu = a_data_reg[559:496];
        w0 = a_data_reg[623:560];

        pinf   = {1'b0, inf_lim_reg};
        ninf   = 64'd0 - pinf;
        ystr   = $signed(yl) < 0 && $signed(yu) > 0;
        yunb   = $signed(yl) < $signed(ninf) || $signed(yu) > $signed(pinf);
        wlo_u  = $signed(wl) < $signed(ninf);
        whi_u  = $signed(wu) > $signed(pinf);
        ysmall = mag(y0) < {31'd0, zero_tol_reg};

        dx    = sat_sub(xu, xl);
        dy    = sat_sub(yu, yl);
        dw    = sat_sub(wu, wl);
        sel_x = $signed(dx) > $signed(dy) && $signed(dx) > $signed(dw);
        sel_y = !($signed(dx) > $signed(dy)) && $signed(dy) > $signed(dw);

        ctrl_next        = '0;
        ctrl_next.cnt    = 2'd1;
        ctrl_next.way    = WAY_RANDOM;
        ctrl_next.use_q  = 1'b1;
        ctrl_next.sc_a   = w0;
        ctrl_next.ysmall = ysmall;
        den              = y0;

        if (ystr)
            ctrl_next.idx = yi;
        else if (yunb)
        begin
            ctrl_next.idx = yi;
            ctrl_next.p1  = near_point(y0, yl, yu, margin_reg, ONE);
            ctrl_next.way = $signed(y0) > 0 ? WAY_LEFT : WAY_RIGHT;
        end
        else if (wlo_u || whi_u)
        begin
            ctrl_next.idx = wi;
            if (wlo_u && whi_u)
            begin
                ctrl_next.minmax = 1'b1;
                ctrl_next.way    = WAY_CENTER;
                ctrl_next.cnt    = 2'd2;
            end
            else
            begin
                ctrl_next.p1  = near_point(w0, wl, wu, margin_reg, ONE);
                ctrl_next.way = wlo_u ? WAY_RIGHT : WAY_LEFT;
            end
        end
        else
        begin
            ctrl_next.ysmall = 1'b0;
            if (sel_x)
            begin
                ctrl_next.idx   = xi;
                ctrl_next.p1    = midpoint(xl, xu);
                ctrl_next.sc_a  = x0;
                ctrl_next.use_q = 1'b0;
            end
            else if (sel_y)
            begin
                ctrl_next.idx  = yi;
                ctrl_next.p1   = midpoint(yl, yu);
                ctrl_next.sc_a = y0;
                den            = w0;
            end
            else
            begin
                ctrl_next.idx = wi;
                ctrl_next.p1  = midpoint(wl, wu);
            end
        end

        ma_y = mag(y0);
        ma_w = mag(w0);
    end

    // Classification register with 32x32 partial products
    logic        b_valid_reg;
    ctrl_t       b_ctrl_reg;
    logic [63:0] b_num_reg, b_den_reg;
    logic [63:0] b_pp_reg [4];
    logic        b_mneg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else if (adv)
            b_valid_reg <= a_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_ctrl_reg  <= ctrl_next;
            b_num_reg   <= x0;
            b_den_reg   <= den;
            b_pp_reg[0] <= ma_y[31:0] * ma_w[31:0];
            b_pp_reg[1] <= ma_y[31:0] * ma_w[63:32];
            b_pp_reg[2] <= ma_y[63:32] * ma_w[31:0];
            b_pp_reg[3] <= ma_y[63:32] * ma_w[63:32];
            b_mneg_reg  <= y0[63] ^ w0[63];
        end
    end

    // Sum the product and set up the divider's first step
    logic [127:0] prod;
    logic [63:0]  num_mag, hi_part;
    ctrl_t        c_ctrl;
    div_t         c_div;

    always_comb
    begin
        prod = {64'd0, b_pp_reg[0]} + {32'd0, b_pp_reg[1], 32'd0}
             + {32'd0, b_pp_reg[2], 32'd0} + {b_pp_reg[3], 64'd0};
        c_ctrl = b_ctrl_reg;
        if (!b_ctrl_reg.use_q)
            c_ctrl.sc_b = from_mag(b_mneg_reg, prod[FRACTION_BITS +: 64],
                                   |prod[127:64+FRACTION_BITS]);

        num_mag     = mag(b_num_reg);
        hi_part     = num_mag >> (WORD_BITS - FRACTION_BITS);
        c_div.d     = mag(b_den_reg);
        c_div.r     = hi_part;
        c_div.lo    = num_mag << FRACTION_BITS;
        c_div.q     = 64'd0;
        c_div.dz    = c_div.d == 64'd0;
        c_div.ovf   = hi_part >= c_div.d;
        c_div.neg   = b_num_reg[63] ^ b_den_reg[63];
        c_div.a_pos = !b_num_reg[63] && b_num_reg != 64'd0;
        c_div.a_neg = b_num_reg[63];
    end

    logic        d_valid;
    logic [63:0] d_quo;
    ctrl_t       d_ctrl;

    dbps_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (b_valid_reg),
        .in_div    (c_div),
        .in_ctrl   (c_ctrl),
        .out_valid (d_valid),
        .out_quo   (d_quo),
        .out_ctrl  (d_ctrl)
    );

    // Final points and score
    logic [63:0] sub_b, p1, p2;
    logic [64:0] diff;
    logic [62:0] score;
    logic        q_lt;

    always_comb
    begin
        sub_b = d_ctrl.use_q ? d_quo : d_ctrl.sc_b;
        diff  = {d_ctrl.sc_a[63], d_ctrl.sc_a} - {sub_b[63], sub_b};
        if (diff[64])
            diff = 65'd0 - diff;
        if (d_ctrl.ysmall)
            score = ONE[62:0];
        else if (diff[64:63] != 2'b00)
            score = SMAX[62:0];
        else
            score = diff[62:0];

        q_lt = $signed(d_quo) < $signed(d_ctrl.sc_a);
        if (d_ctrl.minmax)
        begin
            p1 = q_lt ? d_quo : d_ctrl.sc_a;
            p2 = q_lt ? d_ctrl.sc_a : d_quo;
        end
        else
        begin
            p1 = d_ctrl.p1;
            p2 = 64'd0;
        end
    end

    // Output register
    logic         out_valid_reg;
    logic [215:0] out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= d_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            out_data_reg <= {5'd0, score, p2, p1, d_ctrl.cnt, d_ctrl.way, d_ctrl.idx};
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

`default_nettype wire
